// ===== design/bpc_pkg.sv =====
// bpc_pkg: shared widths, codes and reset values for the button press classifier
// used by button_press_classifier_unit and its checker bpc_checker
// no dependencies

package bpc_pkg;

    localparam int TIME_W      = 32;  // microsecond timestamp width
    localparam int THR_W       = 24;  // width of every timing register
    localparam int EV_W        = 3;   // event code width
    localparam int CFG_IDX_W   = 3;   // register index width on the config port
    localparam int BTN_N       = 3;   // right, enter, left
    localparam int IN_TDATA_W  = 40;  // now_us, right, enter, left, padding
    localparam int OUT_TDATA_W = 8;   // event_res, padding

    // button slots in the per-button state
    localparam int BTN_RIGHT = 0;
    localparam int BTN_ENTER = 1;
    localparam int BTN_LEFT  = 2;

    // opcodes carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_REPEAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET       = 3'd3;

    // register reset values
    localparam logic [THR_W-1:0] RST_SHORT_THR   = 24'd100000;
    localparam logic [THR_W-1:0] RST_LONG_THR    = 24'd500000;
    localparam logic [THR_W-1:0] RST_LONG_REPEAT = 24'd500000;
    localparam logic [THR_W-1:0] RST_QUIET       = 24'd10000;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EV_W-1:0] EV_RIGHT_LONG  = 3'd1;
    localparam logic [EV_W-1:0] EV_LEFT_LONG   = 3'd2;
    localparam logic [EV_W-1:0] EV_RIGHT_SHORT = 3'd3;
    localparam logic [EV_W-1:0] EV_LEFT_SHORT  = 3'd4;
    localparam logic [EV_W-1:0] EV_ENTER_SHORT = 3'd5;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [THR_W-1:0]  t_thr;

endpackage

// ===== design/button_press_classifier_unit.sv =====
// button_press_classifier_unit: short and long press classifier for three buttons
// depends on bpc_pkg

// One word is taken per clock unless an evaluate word waits in the input
// register. A word enters an input register, and from there a single stage of
// compares and 32-bit wrapping subtractions updates the per-button state (first
// seen, last seen, handled start, last long event) and, for an evaluate word,
// loads the event code into the output register. An evaluate word's result thus
// passes the input register and then the output register; a sample word gives
// no result. The state update stage is the only loop, so the sustained rate is
// one word per cycle as long as the output side keeps taking results; a stalled
// result holds back the next evaluate word and whatever queues behind it, while
// sample words ahead of that still flow past it. Events are checked in the order
// right long, left long, right short, left short, enter short, and only the
// first that passes fires.
// Timing registers are written through the config port at any time, but are
// meant to change only while no word is in flight; writes to indexes four and
// above are dropped.

module button_press_classifier_unit
    import bpc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] now_us, [32] right_down,
                                                  // [33] enter_down, [34] left_down,
                                                  // [39:35] zero
    input  logic                   s_axis_tuser,  // [0] opcode
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] event_res, [7:3] zero
    // register write port
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [THR_W-1:0]       i_cfg_data
);

    // timing registers
    t_thr r_short_thr, r_long_thr, r_long_rep, r_quiet;

    // input register
    logic             r_in_valid;
    logic             r_in_op;
    t_time            r_in_now;
    logic [BTN_N-1:0] r_in_down;

    // output register
    logic            r_out_valid;
    logic [EV_W-1:0] r_ev;

    // per-button state
    t_time r_first   [BTN_N];
    t_time r_last    [BTN_N];
    t_time r_handled [BTN_N];
    t_time r_long_t  [BTN_N];

    t_time n_first   [BTN_N];
    t_time n_last    [BTN_N];
    t_time n_handled [BTN_N];
    t_time n_long_t  [BTN_N];

    logic            stage_fire;
    logic            s_accept;
    logic [BTN_N-1:0] long_ok, short_ok, sel_long, sel_short;
    logic [EV_W-1:0] n_ev;

    assign o_cfg_ready = 1'b1;

    // an evaluate word waits only while an untaken result sits in the output register
    assign stage_fire    = r_in_valid &&
                           (r_in_op == OP_SAMPLE || !r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || stage_fire);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-EV_W){1'b0}}, r_ev};

    // register writes, low 24 bits kept by the port width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr <= RST_SHORT_THR;
            r_long_thr  <= RST_LONG_THR;
            r_long_rep  <= RST_LONG_REPEAT;
            r_quiet     <= RST_QUIET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SHORT_THR:   r_short_thr <= i_cfg_data;
                REG_LONG_THR:    r_long_thr  <= i_cfg_data;
                REG_LONG_REPEAT: r_long_rep  <= i_cfg_data;
                REG_QUIET:       r_quiet     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-button checks, all buttons in parallel
    always_comb begin
        t_time held, quiet, since_long;
        logic  active;
        for (int b = 0; b < BTN_N; b++) begin
            held       = r_last[b] - r_first[b];
            quiet      = r_in_now - r_last[b];
            since_long = r_in_now - r_long_t[b];
            active     = (r_first[b] != '0);
            long_ok[b]  = active && (held > {8'd0, r_long_thr}) &&
                          (since_long > {8'd0, r_long_rep});
            short_ok[b] = active && (quiet > {8'd0, r_quiet}) &&
                          (held > {8'd0, r_short_thr}) && (r_first[b] > r_handled[b]);
        end
    end

    // fixed priority: right long, left long, right short, left short, enter short
    always_comb begin
        sel_long  = '0;
        sel_short = '0;
        n_ev      = EV_NONE;
        if (long_ok[BTN_RIGHT]) begin
            sel_long[BTN_RIGHT] = 1'b1;
            n_ev = EV_RIGHT_LONG;
        end else if (long_ok[BTN_LEFT]) begin
            sel_long[BTN_LEFT] = 1'b1;
            n_ev = EV_LEFT_LONG;
        end else if (short_ok[BTN_RIGHT]) begin
            sel_short[BTN_RIGHT] = 1'b1;
            n_ev = EV_RIGHT_SHORT;
        end else if (short_ok[BTN_LEFT]) begin
            sel_short[BTN_LEFT] = 1'b1;
            n_ev = EV_LEFT_SHORT;
        end else if (short_ok[BTN_ENTER]) begin
            sel_short[BTN_ENTER] = 1'b1;
            n_ev = EV_ENTER_SHORT;
        end
    end

    // next state of each button
    always_comb begin
        for (int b = 0; b < BTN_N; b++) begin
            n_first[b]   = r_first[b];
            n_last[b]    = r_last[b];
            n_handled[b] = r_handled[b];
            n_long_t[b]  = r_long_t[b];
            if (r_in_op == OP_SAMPLE) begin
                if (r_in_down[b]) begin
                    // a press seen at time zero keeps the no-press mark
                    if (r_first[b] == '0) begin
                        n_first[b] = r_in_now;
                    end
                    n_last[b] = r_in_now;
                end
            end else begin
                if (sel_long[b]) begin
                    n_long_t[b]  = r_in_now;
                    n_handled[b] = r_first[b];
                end
                if (sel_short[b]) begin
                    n_handled[b] = r_first[b];
                end
                // handled press gone quiet: forget it
                if ((r_last[b] != '0) && ((r_in_now - r_last[b]) > {8'd0, r_quiet}) &&
                    (r_first[b] == n_handled[b])) begin
                    n_first[b] = '0;
                    n_last[b]  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < BTN_N; b++) begin
                r_first[b]   <= '0;
                r_last[b]    <= '0;
                r_handled[b] <= '0;
                r_long_t[b]  <= '0;
            end
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (stage_fire) begin
                r_in_valid <= 1'b0;
            end

            if (stage_fire && r_in_op == OP_EVAL) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (stage_fire) begin
                for (int b = 0; b < BTN_N; b++) begin
                    r_first[b]   <= n_first[b];
                    r_last[b]    <= n_last[b];
                    r_handled[b] <= n_handled[b];
                    r_long_t[b]  <= n_long_t[b];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_op              <= s_axis_tuser;
            r_in_now             <= s_axis_tdata[TIME_W-1:0];
            r_in_down[BTN_RIGHT] <= s_axis_tdata[TIME_W];
            r_in_down[BTN_ENTER] <= s_axis_tdata[TIME_W+1];
            r_in_down[BTN_LEFT]  <= s_axis_tdata[TIME_W+2];
        end
        if (stage_fire && r_in_op == OP_EVAL) begin
            r_ev <= n_ev;
        end
    end

endmodule

// ===== design/bpc_checker.sv =====
// bpc_checker: port-level assertions for button_press_classifier_unit
// depends on bpc_pkg; bound to the top level at the end of this file

module bpc_checker
    import bpc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic s_acc_eval;
    assign s_acc_eval = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_EVAL);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // only defined event codes, padding zero
    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[EV_W-1:0] <= EV_ENTER_SHORT) &&
                          (m_axis_tdata[OUT_TDATA_W-1:EV_W] == '0))
        else $error("event code out of range");

    // a result appearing from an empty output stems from an accepted evaluate word
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_acc_eval, 2))
        else $error("result without evaluate word");

    // an evaluate word reaching a free output shows its result after the input and output registers
    a_eval_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(s_acc_eval, 2) && !$past(m_axis_tvalid) |-> m_axis_tvalid)
        else $error("evaluate word gave no result");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (.*);

// ===== tb/tb_button_press_classifier_unit.sv =====
// tb_button_press_classifier_unit: self-checking bench for button_press_classifier_unit
// predicts every event code from its own copy of the press state and timing registers
// depends on bpc_pkg and button_press_classifier_unit

module tb_button_press_classifier_unit;
    import bpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles to let a sample word clear the two-stage pipe before a register write
    localparam int SETTLE_CYCLES = 8;
    // words per timing setting in the random part
    localparam int RAND_WORDS    = 100;
    // mismatch lines printed before going quiet
    localparam int MAX_PRINTS    = 40;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] now_us, [32] right, [33] enter,
                                                 // [34] left, [39:35] zero
    logic                   s_axis_tuser  = OP_SAMPLE;  // [0] opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [2:0] event_res, [7:3] zero
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = REG_SHORT_THR;
    logic [THR_W-1:0]       i_cfg_data    = '0;

    button_press_classifier_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // press state as the block should hold it
    // ------------------------------------------------------------------
    t_time first_seen_us   [BTN_N];
    t_time last_seen_us    [BTN_N];
    t_time handled_from_us [BTN_N];  // first-seen time of the last press that fired
    t_time last_long_us    [BTN_N];  // time of the last long event
    t_thr  short_thr;
    t_thr  long_thr;
    t_thr  repeat_thr;
    t_thr  quiet_thr;

    logic [EV_W-1:0] expected_events [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned n_mismatch    = 0;
    int unsigned n_words_in    = 0;
    int unsigned n_results     = 0;
    int unsigned n_settings    = 0;
    int unsigned n_event [EV_ENTER_SHORT+1];

    function automatic void reset_press_model();
        for (int b = 0; b < BTN_N; b++) begin
            first_seen_us[b]   = '0;
            last_seen_us[b]    = '0;
            handled_from_us[b] = '0;
            last_long_us[b]    = '0;
        end
        short_thr  = RST_SHORT_THR;
        long_thr   = RST_LONG_THR;
        repeat_thr = RST_LONG_REPEAT;
        quiet_thr  = RST_QUIET;
    endfunction

    function automatic void write_timing_reg(logic [CFG_IDX_W-1:0] idx, t_thr value);
        case (idx)
            REG_SHORT_THR:   short_thr  = value;
            REG_LONG_THR:    long_thr   = value;
            REG_LONG_REPEAT: repeat_thr = value;
            REG_QUIET:       quiet_thr  = value;
            default: ;  // unused index, dropped
        endcase
    endfunction

    // a zero first-seen time means no press, so a press seen at time zero stays absent
    function automatic void sample_levels(t_time now, logic [BTN_N-1:0] down);
        for (int b = 0; b < BTN_N; b++) begin
            if (down[b]) begin
                if (first_seen_us[b] == '0) first_seen_us[b] = now;
                last_seen_us[b] = now;
            end
        end
    endfunction

    // long press held past the threshold, repeating no faster than the repeat spacing
    function automatic bit long_press_due(int b, t_time now);
        t_time held_us;
        t_time since_long_us;
        held_us       = last_seen_us[b] - first_seen_us[b];
        since_long_us = now - last_long_us[b];
        if (first_seen_us[b] == '0 || held_us <= t_time'(long_thr) ||
            since_long_us <= t_time'(repeat_thr)) return 1'b0;
        last_long_us[b]    = now;
        handled_from_us[b] = first_seen_us[b];
        return 1'b1;
    endfunction

    // released press held past the short threshold and not fired yet
    function automatic bit short_press_due(int b, t_time now);
        t_time held_us;
        t_time quiet_us;
        held_us  = last_seen_us[b] - first_seen_us[b];
        quiet_us = now - last_seen_us[b];
        if (first_seen_us[b] == '0 || quiet_us <= t_time'(quiet_thr) ||
            held_us <= t_time'(short_thr) || first_seen_us[b] <= handled_from_us[b])
            return 1'b0;
        handled_from_us[b] = first_seen_us[b];
        return 1'b1;
    endfunction

    function automatic logic [EV_W-1:0] classify_eval(t_time now);
        logic [EV_W-1:0] ev;
        t_time           quiet_us;
        // fixed priority, only the first passing check takes effect
        if (long_press_due(BTN_RIGHT, now))        ev = EV_RIGHT_LONG;
        else if (long_press_due(BTN_LEFT, now))    ev = EV_LEFT_LONG;
        else if (short_press_due(BTN_RIGHT, now))  ev = EV_RIGHT_SHORT;
        else if (short_press_due(BTN_LEFT, now))   ev = EV_LEFT_SHORT;
        else if (short_press_due(BTN_ENTER, now))  ev = EV_ENTER_SHORT;
        else                                       ev = EV_NONE;
        // handled presses that have gone quiet are forgotten
        for (int b = 0; b < BTN_N; b++) begin
            quiet_us = now - last_seen_us[b];
            if (last_seen_us[b] != '0 && quiet_us > t_time'(quiet_thr) &&
                first_seen_us[b] == handled_from_us[b]) begin
                first_seen_us[b] = '0;
                last_seen_us[b]  = '0;
            end
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s, expected %0d, got %0d", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // monitor: checks each result word, then predicts from each accepted word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic [EV_W-1:0] want;
        t_time           now;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_events.size() == 0) begin
                    report_mismatch("result word with no event pending", 0,
                                    32'(m_axis_tdata));
                end else begin
                    want = expected_events.pop_front();
                    if (m_axis_tdata[EV_W-1:0] !== want)
                        report_mismatch("event_res", 32'(want),
                                        32'(m_axis_tdata[EV_W-1:0]));
                    if (m_axis_tdata[OUT_TDATA_W-1:EV_W] !== '0)
                        report_mismatch("result padding", 0,
                                        32'(m_axis_tdata[OUT_TDATA_W-1:EV_W]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_words_in++;
                now = s_axis_tdata[TIME_W-1:0];
                if (s_axis_tuser == OP_EVAL) begin
                    want = classify_eval(now);
                    n_event[want]++;
                    expected_events.push_back(want);
                end else begin
                    sample_levels(now, s_axis_tdata[TIME_W +: BTN_N]);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                write_timing_reg(i_cfg_index, i_cfg_data);
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // valid stays high from one word to the next unless an idle cycle is drawn
    task automatic send_word(input logic op, input t_time now, input logic [BTN_N-1:0] down);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W-TIME_W-BTN_N){1'b0}}, down, now};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop the stream and wait for every pending event plus the pipe to empty
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        // let the monitor queue the last accepted word first
        @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // back-to-back register writes, valid only dropped once the last one is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_thr value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_timing(input t_thr shrt, input t_thr lng, input t_thr rpt,
                                input t_thr quiet);
        drain_pipe();
        write_reg(REG_SHORT_THR, shrt);
        write_reg(REG_LONG_THR, lng);
        write_reg(REG_LONG_REPEAT, rpt);
        write_reg(REG_QUIET, quiet);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic t_thr pick_threshold();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return t_thr'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    function automatic t_thr small_threshold();
        return t_thr'($urandom_range(0, 3000));
    endfunction

    // mostly plausible press sequences: time moves forward in steps scaled to the
    // current thresholds and each button tends to keep its level; a few noise words
    task automatic run_press_sequences(input int unsigned n_words);
        t_time            now;
        logic [BTN_N-1:0] levels;
        int unsigned      span;
        int unsigned      roll;
        span = 32'(long_thr);
        if (short_thr > span)  span = 32'(short_thr);
        if (repeat_thr > span) span = 32'(repeat_thr);
        if (quiet_thr > span)  span = 32'(quiet_thr);
        span   = span + 1;
        levels = '0;
        // start anywhere, often just short of the wrap
        if ($urandom_range(0, 2) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 3 * span);
        else                           now = $urandom;
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(0, 99) < 6) begin
                send_word(1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 45)      now = now + $urandom_range(0, quiet_thr + 1);
                else if (roll < 85) now = now + $urandom_range(0, span);
                else                now = now + $urandom_range(span, 3 * span);
                for (int b = 0; b < BTN_N; b++)
                    if ($urandom_range(0, 99) < 15) levels[b] = ~levels[b];
                send_word(($urandom_range(0, 99) < 35) ? OP_EVAL : OP_SAMPLE, now, levels);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset timing: empty state, time zero, each short event, priority, long repeat, wrap
    task automatic test_default_timing();
        send_word(OP_EVAL,   32'd0, 3'b000);
        send_word(OP_SAMPLE, 32'd0, 3'b111);          // press at time zero counts as absent
        send_word(OP_EVAL,   32'hFFFF_FFFF, 3'b000);
        // right short press, released and quiet
        send_word(OP_SAMPLE, 32'd1000, 3'b001);
        send_word(OP_SAMPLE, 32'd200000, 3'b001);
        send_word(OP_EVAL,   32'd300000, 3'b000);
        send_word(OP_SAMPLE, 32'd350000, 3'b000);
        // all three short together: right, then left, then enter
        send_word(OP_SAMPLE, 32'd400000, 3'b111);
        send_word(OP_SAMPLE, 32'd550000, 3'b111);
        send_word(OP_EVAL,   32'd600000, 3'b000);
        send_word(OP_EVAL,   32'd600001, 3'b000);
        send_word(OP_EVAL,   32'd600002, 3'b000);
        // right and left held long: right long, left long, repeat held off, then repeat
        send_word(OP_SAMPLE, 32'd1000000, 3'b101);
        send_word(OP_SAMPLE, 32'd1600000, 3'b101);
        send_word(OP_EVAL,   32'd1600001, 3'b000);
        send_word(OP_EVAL,   32'd1600002, 3'b000);
        send_word(OP_EVAL,   32'd1600003, 3'b000);
        send_word(OP_SAMPLE, 32'd2200000, 3'b101);
        send_word(OP_EVAL,   32'd2200001, 3'b000);
        send_word(OP_EVAL,   32'd2400000, 3'b000);  // long handled, then cleared
        // press spanning the 32-bit wrap
        send_word(OP_SAMPLE, 32'hFFFF_FF00, 3'b001);
        send_word(OP_SAMPLE, 32'h0002_0000, 3'b001);
        send_word(OP_EVAL,   32'h0004_0000, 3'b000);
    endtask

    // writes to unused indexes are dropped; zero thresholds fire on any press with a nonzero held time
    task automatic test_zero_timing_and_unused_regs();
        drain_pipe();
        for (int idx = REG_QUIET + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), '1);
        i_cfg_valid <= 1'b0;
        apply_timing('0, '0, '0, '0);
        send_word(OP_SAMPLE, 32'd5, 3'b010);
        send_word(OP_SAMPLE, 32'd6, 3'b010);
        send_word(OP_EVAL,   32'd7, 3'b000);
        send_word(OP_EVAL,   32'd7, 3'b000);
    endtask

    task automatic test_random_slow_receiver();
        send_idle_pct = 13;
        recv_idle_pct = 80;
        apply_timing(RST_SHORT_THR, RST_LONG_THR, RST_LONG_REPEAT, RST_QUIET);
        run_press_sequences(RAND_WORDS);
        apply_timing('1, '1, '1, '1);
        run_press_sequences(RAND_WORDS);
    endtask

    task automatic test_random_slow_sender();
        send_idle_pct = 80;
        recv_idle_pct = 13;
        apply_timing(t_thr'($urandom), t_thr'($urandom), t_thr'($urandom), t_thr'($urandom));
        run_press_sequences(RAND_WORDS);
        apply_timing(small_threshold(), small_threshold(), small_threshold(),
                     small_threshold());
        run_press_sequences(RAND_WORDS);
    endtask

    task automatic test_random_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_timing(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold());
        run_press_sequences(RAND_WORDS);
        apply_timing(small_threshold(), small_threshold(), small_threshold(),
                     small_threshold());
        run_press_sequences(RAND_WORDS);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (n_event[e]) n_event[e] = 0;
        reset_press_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 13;
        recv_idle_pct = 80;
        test_default_timing();
        test_zero_timing_and_unused_regs();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_no_idle();
        drain_pipe();

        $display("summary: %0d input words, %0d result words, %0d timing settings",
                 n_words_in, n_results, n_settings);
        $display({"summary: events none %0d, right long %0d, left long %0d, ",
                  "right short %0d, left short %0d, enter short %0d"},
                 n_event[EV_NONE], n_event[EV_RIGHT_LONG], n_event[EV_LEFT_LONG],
                 n_event[EV_RIGHT_SHORT], n_event[EV_LEFT_SHORT], n_event[EV_ENTER_SHORT]);
        if (n_mismatch == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d events still pending", expected_events.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
